[design/assert_macros.svh]
// Assertion macros shared by the FEN parser RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is high.
`define FPP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPP_ASSERT(lbl, clk, rst, prop, msg)
`define FPP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[design/fpp_pkg.sv]
// Shared types and constants of the FEN position parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package fpp_pkg;

  // Queue between the classifier and the parser core.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field positions inside the FEN text.
  localparam logic [2:0] FIELD_PLACE  = 3'd0;
  localparam logic [2:0] FIELD_SIDE   = 3'd1;
  localparam logic [2:0] FIELD_CASTLE = 3'd2;
  localparam logic [2:0] FIELD_EP     = 3'd3;
  localparam logic [2:0] FIELD_HALF   = 3'd4;
  localparam logic [2:0] FIELD_FULL   = 3'd5;
  localparam logic [2:0] FIELD_DONE   = 3'd6;

  // Piece type codes.
  localparam logic [2:0] PIECE_PAWN   = 3'd0;
  localparam logic [2:0] PIECE_KNIGHT = 3'd1;
  localparam logic [2:0] PIECE_BISHOP = 3'd2;
  localparam logic [2:0] PIECE_ROOK   = 3'd3;
  localparam logic [2:0] PIECE_QUEEN  = 3'd4;
  localparam logic [2:0] PIECE_KING   = 3'd5;

  // Board and counter limits.
  localparam logic [3:0]  BOARD_WIDTH   = 4'd8;
  localparam logic [2:0]  LAST_RANK     = 3'd7;
  localparam logic [33:0] COUNTER_LIMIT = 34'd1000000000;
  localparam logic [6:0]  EP_NONE       = 7'd64;

  // Characters of interest.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_EIGHT = "8";
  localparam logic [7:0] CH_UP_A  = "A";
  localparam logic [7:0] CH_UP_Z  = "Z";
  localparam logic [7:0] CH_LO_A  = "a";
  localparam logic [7:0] CH_LO_H  = "h";
  localparam logic [7:0] CH_LO_W  = "w";
  localparam logic [7:0] CH_LO_B  = "b";
  localparam logic [7:0] CH_LO_P  = "p";
  localparam logic [7:0] CH_LO_N  = "n";
  localparam logic [7:0] CH_LO_R  = "r";
  localparam logic [7:0] CH_LO_Q  = "q";
  localparam logic [7:0] CH_LO_K  = "k";
  localparam logic [7:0] CH_UP_K  = "K";
  localparam logic [7:0] CH_UP_Q  = "Q";
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // One classified text byte as it waits in the queue.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       space;
    logic       digit;
    logic [3:0] dval;
    logic       piece_ok;
    logic       pcolor;
    logic [2:0] ptype;
  } item_t;

  // Output word layout.
  localparam int TDATA_W = 88;

endpackage

`default_nettype wire

[design/fpp_front.sv]
// Front end of the FEN parser: classifies each accepted text byte.
// Depends on fpp_pkg for the item type and character constants.
`default_nettype none

module fpp_front
  import fpp_pkg::*;
(
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_text,
  output item_t           item
);

  logic       upper;
  logic [7:0] low;

  // Fold upper case letters to lower case for the piece lookup.
  assign upper = (char_in >= CH_UP_A) && (char_in <= CH_UP_Z);
  assign low   = upper ? char_in + CASE_OFFSET : char_in;

  // Character classes and piece decode.
  always_comb begin
    item.ch       = char_in;
    item.eot      = end_of_text;
    item.space    = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    item.digit    = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    item.dval     = char_in[3:0];
    item.pcolor   = !upper;
    item.piece_ok = 1'b1;
    item.ptype    = PIECE_PAWN;
    case (low)
      CH_LO_P: item.ptype = PIECE_PAWN;
      CH_LO_N: item.ptype = PIECE_KNIGHT;
      CH_LO_B: item.ptype = PIECE_BISHOP;
      CH_LO_R: item.ptype = PIECE_ROOK;
      CH_LO_Q: item.ptype = PIECE_QUEEN;
      CH_LO_K: item.ptype = PIECE_KING;
      default: item.piece_ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/fpp_queue.sv]
// Short queue of classified bytes between the front end and the parser core.
// Depends on fpp_pkg for the item type and queue depth.
`default_nettype none

`include "assert_macros.svh"

module fpp_queue
  import fpp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  output logic       not_empty,
  input  wire logic  pop,
  output item_t      head
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `FPP_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `FPP_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + QCNT_W'(1)), "queue count did not grow")
  `FPP_ASSERT(a_count_down, clk, rst, (pop && !push) |=> (count == $past(count) - QCNT_W'(1)), "queue count did not shrink")

endmodule

`default_nettype wire

[design/fpp_back.sv]
// Parser core of the FEN parser: runs the field state per byte and drives the
// output register. Depends on fpp_pkg for types, field codes and constants.
`default_nettype none

`include "assert_macros.svh"

module fpp_back
  import fpp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire item_t              item,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,
  output logic                    m_tuser
);

  // Parser state.
  logic [2:0]  field_index;
  logic        in_token;
  logic        failed;
  logic [2:0]  rank_count;
  logic [3:0]  file_count;
  logic [1:0]  white_king_count;
  logic [1:0]  black_king_count;
  logic        side_reg;
  logic [3:0]  castle_mask;
  logic [1:0]  token_length;
  logic        dash_seen;
  logic [6:0]  ep_reg;
  logic [29:0] halfmove_acc;
  logic [29:0] fullmove_acc;

  logic [2:0]  field_index_next;
  logic        in_token_next;
  logic        failed_next;
  logic [2:0]  rank_count_next;
  logic [3:0]  file_count_next;
  logic [1:0]  white_king_count_next;
  logic [1:0]  black_king_count_next;
  logic        side_reg_next;
  logic [3:0]  castle_mask_next;
  logic [1:0]  token_length_next;
  logic        dash_seen_next;
  logic [6:0]  ep_reg_next;
  logic [29:0] halfmove_acc_next;
  logic [29:0] fullmove_acc_next;

  logic        piece;
  logic [2:0]  piece_col;
  logic [2:0]  piece_row;
  logic        verdict_ok;
  logic [4:0]  file_sum;
  logic [7:0]  rank_digit;
  logic        has_result;

  // True when closing the current token breaks a field check.
  function automatic logic close_fails(input logic [2:0] fi, input logic [2:0] rc,
                                       input logic [3:0] fc, input logic [1:0] wk,
                                       input logic [1:0] bk, input logic [1:0] tl,
                                       input logic ds);
    logic bad;
    bad = 1'b0;
    if (fi == FIELD_PLACE) begin
      bad = (rc != LAST_RANK) || (fc != BOARD_WIDTH) || (wk != 2'd1) || (bk != 2'd1);
    end else if (fi == FIELD_EP) begin
      bad = (tl == 2'd1) && !ds;
    end
    return bad;
  endfunction

  // Decimal accumulate: bit 30 flags a bad digit or a value over the limit.
  function automatic logic [30:0] add_digit(input logic [29:0] acc, input logic dig,
                                            input logic [3:0] dv);
    logic [33:0] v;
    logic [30:0] res;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {30'd0, dv};
    if (!dig || (v > COUNTER_LIMIT)) begin
      res = {1'b1, acc};
    end else begin
      res = {1'b0, v[29:0]};
    end
    return res;
  endfunction

  assign file_sum   = {1'b0, file_count} + {1'b0, item.dval};
  assign rank_digit = item.ch - CH_ONE;

  // Next parser state for the byte at the head of the queue.
  always_comb begin
    logic [30:0] acc_res;
    field_index_next      = field_index;
    in_token_next         = in_token;
    failed_next           = failed;
    rank_count_next       = rank_count;
    file_count_next       = file_count;
    white_king_count_next = white_king_count;
    black_king_count_next = black_king_count;
    side_reg_next         = side_reg;
    castle_mask_next      = castle_mask;
    token_length_next     = token_length;
    dash_seen_next        = dash_seen;
    ep_reg_next           = ep_reg;
    halfmove_acc_next     = halfmove_acc;
    fullmove_acc_next     = fullmove_acc;
    piece                 = 1'b0;
    piece_col             = file_count[2:0];
    piece_row             = rank_count;
    acc_res               = '0;

    if (!failed && (field_index < FIELD_DONE)) begin
      if (item.space) begin
        // Whitespace closes an open token.
        if (in_token) begin
          if (close_fails(field_index, rank_count, file_count, white_king_count,
                          black_king_count, token_length, dash_seen)) begin
            failed_next = 1'b1;
          end
          field_index_next = field_index + 3'd1;
          in_token_next    = 1'b0;
        end
      end else if (field_index == FIELD_SIDE) begin
        // Side to move is a single byte.
        if (item.ch == CH_LO_W) begin
          side_reg_next = 1'b0;
        end else if (item.ch == CH_LO_B) begin
          side_reg_next = 1'b1;
        end else begin
          failed_next = 1'b1;
        end
        field_index_next = FIELD_CASTLE;
        in_token_next    = 1'b0;
      end else begin
        if (!in_token) begin
          in_token_next     = 1'b1;
          token_length_next = 2'd0;
          dash_seen_next    = 1'b0;
        end
        case (field_index)
          FIELD_PLACE: begin
            if (item.ch == CH_SLASH) begin
              if ((file_count != BOARD_WIDTH) || (rank_count >= LAST_RANK)) begin
                failed_next = 1'b1;
              end else begin
                rank_count_next = rank_count + 3'd1;
                file_count_next = 4'd0;
              end
            end else if (item.digit) begin
              if ((item.dval == 4'd0) || (file_sum > {1'b0, BOARD_WIDTH})) begin
                failed_next = 1'b1;
              end else begin
                file_count_next = file_sum[3:0];
              end
            end else if ((file_count >= BOARD_WIDTH) || !item.piece_ok) begin
              failed_next = 1'b1;
            end else begin
              piece           = 1'b1;
              file_count_next = file_count + 4'd1;
              if (item.ptype == PIECE_KING) begin
                if (!item.pcolor && (white_king_count < 2'd2)) begin
                  white_king_count_next = white_king_count + 2'd1;
                end
                if (item.pcolor && (black_king_count < 2'd2)) begin
                  black_king_count_next = black_king_count + 2'd1;
                end
              end
            end
          end
          FIELD_CASTLE: begin
            if (item.ch == CH_DASH) begin
              if (token_length_next == 2'd0) begin
                dash_seen_next = 1'b1;
              end else begin
                failed_next = 1'b1;
              end
            end else if (dash_seen_next) begin
              failed_next = 1'b1;
            end else if (item.ch == CH_UP_K) begin
              castle_mask_next = castle_mask | 4'b0001;
            end else if (item.ch == CH_UP_Q) begin
              castle_mask_next = castle_mask | 4'b0010;
            end else if (item.ch == CH_LO_K) begin
              castle_mask_next = castle_mask | 4'b0100;
            end else if (item.ch == CH_LO_Q) begin
              castle_mask_next = castle_mask | 4'b1000;
            end else begin
              failed_next = 1'b1;
            end
          end
          FIELD_EP: begin
            if (token_length_next == 2'd0) begin
              if (item.ch == CH_DASH) begin
                dash_seen_next = 1'b1;
                ep_reg_next    = EP_NONE;
              end else if ((item.ch >= CH_LO_A) && (item.ch <= CH_LO_H)) begin
                ep_reg_next = {4'd0, item.ch[2:0] - CH_LO_A[2:0]};
              end else begin
                failed_next = 1'b1;
              end
            end else if (token_length_next == 2'd1) begin
              if (dash_seen_next || (item.ch < CH_ONE) || (item.ch > CH_EIGHT)) begin
                failed_next = 1'b1;
              end else begin
                ep_reg_next = {1'b0, rank_digit[2:0], ep_reg[2:0]};
              end
            end else begin
              failed_next = 1'b1;
            end
          end
          FIELD_HALF: begin
            acc_res           = add_digit(halfmove_acc, item.digit, item.dval);
            halfmove_acc_next = acc_res[29:0];
            if (acc_res[30]) begin
              failed_next = 1'b1;
            end
          end
          default: begin
            acc_res           = add_digit(fullmove_acc, item.digit, item.dval);
            fullmove_acc_next = acc_res[29:0];
            if (acc_res[30]) begin
              failed_next = 1'b1;
            end
          end
        endcase
        if (token_length_next < 2'd3) begin
          token_length_next = token_length_next + 2'd1;
        end
      end
    end

    // The last byte closes whatever token is still open.
    if (item.eot && !failed_next && in_token_next && (field_index_next < FIELD_DONE)) begin
      if (close_fails(field_index_next, rank_count_next, file_count_next,
                      white_king_count_next, black_king_count_next,
                      token_length_next, dash_seen_next)) begin
        failed_next = 1'b1;
      end
      field_index_next = field_index_next + 3'd1;
      in_token_next    = 1'b0;
    end
  end

  assign verdict_ok = !failed_next && (field_index_next >= FIELD_DONE) &&
                      (fullmove_acc_next != 30'd0);
  assign has_result = item.eot || piece;
  assign pop        = item_valid && (!m_tvalid || m_tready);

  // Parser state update; a verdict returns everything to its reset values.
  always_ff @(posedge clk) begin
    if (rst || (pop && item.eot)) begin
      field_index      <= FIELD_PLACE;
      in_token         <= 1'b0;
      failed           <= 1'b0;
      rank_count       <= 3'd0;
      file_count       <= 4'd0;
      white_king_count <= 2'd0;
      black_king_count <= 2'd0;
      side_reg         <= 1'b0;
      castle_mask      <= 4'd0;
      token_length     <= 2'd0;
      dash_seen        <= 1'b0;
      ep_reg           <= EP_NONE;
      halfmove_acc     <= 30'd0;
      fullmove_acc     <= 30'd0;
    end else if (pop) begin
      field_index      <= field_index_next;
      in_token         <= in_token_next;
      failed           <= failed_next;
      rank_count       <= rank_count_next;
      file_count       <= file_count_next;
      white_king_count <= white_king_count_next;
      black_king_count <= black_king_count_next;
      side_reg         <= side_reg_next;
      castle_mask      <= castle_mask_next;
      token_length     <= token_length_next;
      dash_seen        <= dash_seen_next;
      ep_reg           <= ep_reg_next;
      halfmove_acc     <= halfmove_acc_next;
      fullmove_acc     <= fullmove_acc_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload: a verdict or a piece placement.
  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      m_tuser <= item.eot;
      if (item.eot) begin
        if (verdict_ok) begin
          m_tdata <= {5'd0, fullmove_acc_next, halfmove_acc_next, ep_reg_next,
                      castle_mask_next, side_reg_next, 1'b1, 10'd0};
        end else begin
          m_tdata <= {5'd0, 30'd0, 30'd0, EP_NONE, 4'd0, 1'b0, 1'b0, 10'd0};
        end
      end else begin
        m_tdata <= {78'd0, item.ptype, item.pcolor, piece_row, piece_col};
      end
    end
  end

  `FPP_ASSERT(a_field_range, clk, rst, field_index <= FIELD_DONE, "field index out of range")
  `FPP_ASSERT(a_file_range, clk, rst, file_count <= BOARD_WIDTH, "file count past board width")
  `FPP_ASSERT(a_verdict_resets, clk, rst, (pop && item.eot) |=> ((field_index == FIELD_PLACE) && !failed && !in_token), "state not cleared after verdict")

endmodule

`default_nettype wire

[design/fen_position_parser.sv]
// FEN position parser top level: classifier, byte queue and parser core.
// A result is registered in the output register when the parser core pops its byte from the queue.
// Throughput: one text byte per cycle while the result receiver does not stall the output.
// Reset (rst, synchronous, active high) empties the queue, clears the output valid
// flag and returns the parser to the start of a new string.
// Depends on fpp_pkg, fpp_front, fpp_queue and fpp_back.
`default_nettype none

module fen_position_parser
  import fpp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Input bytes. tdata: char_in[7:0]. tlast: end_of_text.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic               s_tlast,
  // Results. tdata from bit 0 up: column[2:0], row[5:3], piece_color[6],
  // piece_type[9:7], valid_res[10], side_to_move[11], castle_rights[15:12],
  // ep_square[22:16], halfmove[52:23], fullmove[82:53], zero fill[87:83].
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata,
  // tuser: is_final.
  output logic                    m_tuser
);

  item_t in_item;
  item_t head_item;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  q_push;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Byte classification.
  fpp_front u_front (
    .char_in     (s_tdata),
    .end_of_text (s_tlast),
    .item        (in_item)
  );

  // Queue between the front end and the parser core.
  fpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (head_item)
  );

  // Parser core and output register.
  fpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (head_item),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for fen_position_parser: streams FEN text one byte per transfer and checks
// every piece placement and end-of-string verdict against a cycle-free predictor.
// Depends on fpp_pkg and the parser RTL only.

module tb_top;
  import fpp_pkg::*;

  // Castling mask bits, side and color codes.
  localparam logic [3:0] CASTLE_WK   = 4'b0001;
  localparam logic [3:0] CASTLE_WQ   = 4'b0010;
  localparam logic [3:0] CASTLE_BK   = 4'b0100;
  localparam logic [3:0] CASTLE_BQ   = 4'b1000;
  localparam logic       SIDE_WHITE  = 1'b0;
  localparam logic       SIDE_BLACK  = 1'b1;
  localparam logic [1:0] TOKEN_SAT   = 2'd3;
  localparam logic [1:0] KING_SAT    = 2'd2;

  localparam int BYTE_GOAL    = 900;
  localparam int DRAIN_CYCLES = 16;

  // One result as seen on the output stream.
  typedef struct packed {
    logic        is_final;
    logic [2:0]  column;
    logic [2:0]  row;
    logic        color;
    logic [2:0]  kind;
    logic        valid;
    logic        side;
    logic [3:0]  castle;
    logic [6:0]  ep;
    logic [29:0] halfmove;
    logic [29:0] fullmove;
  } fen_result_t;

  typedef logic [7:0] text_q_t[$];

  // One directed string, with its verdict typed in where it is obvious.
  typedef struct {
    string       txt;
    bit          typed;
    fen_result_t verdict;
  } fen_case_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tuser;

  logic                 verdict_typed = 1'b0;
  fen_result_t          verdict_table = '0;
  int                   error_count = 0;
  int                   tx_calm = 0;
  fen_result_t          pending_results[$];
  fen_case_t            fen_cases[$];

  fen_position_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Parser predictor state.
  // ------------------------------------------------------------------
  logic [2:0]  fld;
  logic        in_tok;
  logic        bad;
  logic [2:0]  ranks_done;
  logic [3:0]  files_used;
  logic [1:0]  white_kings;
  logic [1:0]  black_kings;
  logic        side_q;
  logic [3:0]  castle_q;
  logic [1:0]  tok_len;
  logic        dash_q;
  logic [6:0]  ep_q;
  logic [29:0] half_q;
  logic [29:0] full_q;

  function automatic void clear_parser();
    fld         = FIELD_PLACE;
    in_tok      = 1'b0;
    bad         = 1'b0;
    ranks_done  = '0;
    files_used  = '0;
    white_kings = '0;
    black_kings = '0;
    side_q      = SIDE_WHITE;
    castle_q    = '0;
    tok_len     = '0;
    dash_q      = 1'b0;
    ep_q        = EP_NONE;
    half_q      = '0;
    full_q      = '0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Ends the current whitespace-delimited field and runs its closing checks.
  function automatic void close_field();
    if (fld == FIELD_PLACE) begin
      if (ranks_done != LAST_RANK || files_used != BOARD_WIDTH ||
          white_kings != 2'd1 || black_kings != 2'd1)
        bad = 1'b1;
    end else if (fld == FIELD_EP) begin
      if (tok_len == 2'd1 && !dash_q) bad = 1'b1;
    end
    fld    = fld + 3'd1;
    in_tok = 1'b0;
  endfunction

  function automatic logic [29:0] add_counter_digit(logic [29:0] acc, logic [7:0] c);
    longint v;
    if (!is_digit(c)) begin
      bad = 1'b1;
      return acc;
    end
    v = longint'(acc) * 10 + longint'(c - CH_ZERO);
    if (v > COUNTER_LIMIT) begin
      bad = 1'b1;
      return acc;
    end
    return v[29:0];
  endfunction

  // Placement field byte; returns 1 with the placed piece filled in.
  function automatic bit place_byte(input logic [7:0] c, output fen_result_t r);
    int         n;
    logic [7:0] low;
    r = '0;
    if (c == CH_SLASH) begin
      if (files_used != BOARD_WIDTH || ranks_done >= LAST_RANK) begin
        bad = 1'b1;
      end else begin
        ranks_done = ranks_done + 3'd1;
        files_used = '0;
      end
      return 1'b0;
    end
    if (is_digit(c)) begin
      n = c - CH_ZERO;
      if (n == 0 || files_used + n > BOARD_WIDTH) bad = 1'b1;
      else files_used = files_used + n[3:0];
      return 1'b0;
    end
    if (files_used >= BOARD_WIDTH) begin
      bad = 1'b1;
      return 1'b0;
    end
    r.color = (c >= CH_UP_A && c <= CH_UP_Z) ? SIDE_WHITE : SIDE_BLACK;
    low = (r.color == SIDE_WHITE) ? c + CASE_OFFSET : c;
    case (low)
      CH_LO_P: r.kind = PIECE_PAWN;
      CH_LO_N: r.kind = PIECE_KNIGHT;
      CH_LO_B: r.kind = PIECE_BISHOP;
      CH_LO_R: r.kind = PIECE_ROOK;
      CH_LO_Q: r.kind = PIECE_QUEEN;
      CH_LO_K: r.kind = PIECE_KING;
      default: begin
        bad = 1'b1;
        return 1'b0;
      end
    endcase
    if (r.kind == PIECE_KING) begin
      if (r.color == SIDE_WHITE) begin
        if (white_kings < KING_SAT) white_kings = white_kings + 2'd1;
      end else begin
        if (black_kings < KING_SAT) black_kings = black_kings + 2'd1;
      end
    end
    r.column   = files_used[2:0];
    r.row      = ranks_done;
    files_used = files_used + 4'd1;
    return 1'b1;
  endfunction

  function automatic void castle_byte(logic [7:0] c);
    if (c == CH_DASH) begin
      if (tok_len == 2'd0) dash_q = 1'b1;
      else bad = 1'b1;
      return;
    end
    if (dash_q) begin
      bad = 1'b1;
      return;
    end
    case (c)
      CH_UP_K: castle_q = castle_q | CASTLE_WK;
      CH_UP_Q: castle_q = castle_q | CASTLE_WQ;
      CH_LO_K: castle_q = castle_q | CASTLE_BK;
      CH_LO_Q: castle_q = castle_q | CASTLE_BQ;
      default: bad = 1'b1;
    endcase
  endfunction

  // En passant square: file letter then rank digit, or a lone dash.
  function automatic void ep_byte(logic [7:0] c);
    logic [7:0] d;
    if (tok_len == 2'd0) begin
      if (c == CH_DASH) begin
        dash_q = 1'b1;
        ep_q   = EP_NONE;
      end else if (c >= CH_LO_A && c <= CH_LO_H) begin
        d    = c - CH_LO_A;
        ep_q = {4'd0, d[2:0]};
      end else begin
        bad = 1'b1;
      end
    end else if (tok_len == 2'd1) begin
      if (dash_q || c < CH_ONE || c > CH_EIGHT) begin
        bad = 1'b1;
      end else begin
        d    = c - CH_ONE;
        ep_q = {1'b0, d[2:0], ep_q[2:0]};
      end
    end else begin
      bad = 1'b1;
    end
  endfunction

  // Advances the predictor by one text byte; returns 1 when a result is due.
  function automatic bit parse_fen_byte(input logic [7:0] c, input logic eot,
                                        output fen_result_t r);
    fen_result_t placed;
    bit          got_piece;
    bit          ok;
    got_piece = 1'b0;
    placed    = '0;
    r         = '0;
    if (!bad && fld < FIELD_DONE) begin
      if (is_blank(c)) begin
        if (in_tok) close_field();
      end else if (fld == FIELD_SIDE) begin
        if (c == CH_LO_W) side_q = SIDE_WHITE;
        else if (c == CH_LO_B) side_q = SIDE_BLACK;
        else bad = 1'b1;
        fld    = FIELD_CASTLE;
        in_tok = 1'b0;
      end else begin
        if (!in_tok) begin
          in_tok  = 1'b1;
          tok_len = '0;
          dash_q  = 1'b0;
        end
        case (fld)
          FIELD_PLACE:  got_piece = place_byte(c, placed);
          FIELD_CASTLE: castle_byte(c);
          FIELD_EP:     ep_byte(c);
          FIELD_HALF:   half_q = add_counter_digit(half_q, c);
          default:      full_q = add_counter_digit(full_q, c);
        endcase
        if (tok_len < TOKEN_SAT) tok_len = tok_len + 2'd1;
      end
    end
    // The final byte always yields the verdict, even if it also placed a piece.
    if (eot) begin
      if (!bad && in_tok && fld < FIELD_DONE) close_field();
      ok = !bad && fld >= FIELD_DONE && full_q != '0;
      r.is_final = 1'b1;
      r.valid    = ok;
      r.side     = ok ? side_q : SIDE_WHITE;
      r.castle   = ok ? castle_q : 4'd0;
      r.ep       = ok ? ep_q : EP_NONE;
      r.halfmove = ok ? half_q : 30'd0;
      r.fullmove = ok ? full_q : 30'd0;
      clear_parser();
      return 1'b1;
    end
    r = placed;
    return got_piece;
  endfunction

  // ------------------------------------------------------------------
  // Scoreboard: predict on each input transfer, check each output transfer.
  // ------------------------------------------------------------------
  task automatic compare_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    fen_result_t want;
    fen_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (parse_fen_byte(s_tdata, s_tlast, want)) begin
          if (want.is_final && verdict_typed) want = verdict_table;
          pending_results.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        got.is_final = m_tuser;
        got.column   = m_tdata[2:0];
        got.row      = m_tdata[5:3];
        got.color    = m_tdata[6];
        got.kind     = m_tdata[9:7];
        got.valid    = m_tdata[10];
        got.side     = m_tdata[11];
        got.castle   = m_tdata[15:12];
        got.ep       = m_tdata[22:16];
        got.halfmove = m_tdata[52:23];
        got.fullmove = m_tdata[82:53];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tuser %0d tdata %h",
                   $time, m_tuser, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("is_final", want.is_final, got.is_final);
          compare_field("column", want.column, got.column);
          compare_field("row", want.row, got.row);
          compare_field("piece_color", want.color, got.color);
          compare_field("piece_type", want.kind, got.kind);
          compare_field("valid_res", want.valid, got.valid);
          compare_field("side_to_move", want.side, got.side);
          compare_field("castle_rights", want.castle, got.castle);
          compare_field("ep_square", want.ep, got.ep);
          compare_field("halfmove", want.halfmove, got.halfmove);
          compare_field("fullmove", want.fullmove, got.fullmove);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers.
  // ------------------------------------------------------------------

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_case(string txt, bit typed, logic ok, logic side, logic [3:0] castle,
                          logic [6:0] ep, logic [29:0] half, logic [29:0] full);
    fen_case_t fc;
    fc.txt              = txt;
    fc.typed            = typed;
    fc.verdict          = '0;
    fc.verdict.is_final = 1'b1;
    fc.verdict.valid    = ok;
    fc.verdict.side     = side;
    fc.verdict.castle   = castle;
    fc.verdict.ep       = ep;
    fc.verdict.halfmove = half;
    fc.verdict.fullmove = full;
    fen_cases.push_back(fc);
  endtask

  // Offers one byte and waits for its transfer.
  task automatic send_byte(logic [7:0] c, logic last);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = idle_length();
      if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(text_q_t txt);
    int i;
    for (i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic append_str(ref text_q_t txt, input string s);
    int i;
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic add_blanks(ref text_q_t txt);
    repeat (($urandom_range(0, 9) == 0) ? 2 : 1) begin
      if ($urandom_range(0, 99) < 80) txt.push_back(CH_SPACE);
      else txt.push_back(8'($urandom_range(CH_TAB, CH_CR)));
    end
  endtask

  // Move counter text: small values, values around the limit, leading zeros,
  // and digit runs long enough to overflow.
  task automatic append_counter(ref text_q_t txt, input bit is_full);
    int    pick;
    string s;
    pick = $urandom_range(0, 99);
    if (is_full && pick < 3) begin
      s = "0";
    end else if (pick < 70) begin
      s = $sformatf("%0d", $urandom_range(is_full ? 1 : 0, 150));
    end else if (pick < 88) begin
      s = $sformatf("%0d", $urandom_range(999_999_990, 1_000_000_005));
    end else if (pick < 94) begin
      s = {"00", $sformatf("%0d", $urandom_range(0, 99))};
    end else begin
      s = "";
      repeat ($urandom_range(10, 12)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    append_str(txt, s);
  endtask

  // Random position string: mostly well formed with random content, the rest
  // corrupted, truncated or plain noise.
  task automatic build_position(output text_q_t txt);
    int          wk_sq;
    int          bk_sq;
    int          density;
    int          empties;
    int          rk;
    int          fl;
    int          sq;
    int          pick;
    int          n;
    logic [7:0]  pc;
    string       pieces;
    string       rights;
    pieces = "PNBRQpnbrq";
    rights = "KQkq";
    txt = {};
    wk_sq = $urandom_range(0, 63);
    do bk_sq = $urandom_range(0, 63); while (bk_sq == wk_sq);
    density = $urandom_range(0, 60);
    for (rk = 0; rk < 8; rk++) begin
      empties = 0;
      for (fl = 0; fl < 8; fl++) begin
        sq = rk * 8 + fl;
        if (sq == wk_sq) pc = CH_UP_K;
        else if (sq == bk_sq) pc = CH_LO_K;
        else if ($urandom_range(0, 99) < density) pc = pieces[$urandom_range(0, 9)];
        else pc = 8'd0;
        if (pc == 8'd0) begin
          empties++;
        end else begin
          if (empties > 0) txt.push_back(8'(CH_ZERO + empties));
          empties = 0;
          txt.push_back(pc);
        end
      end
      if (empties > 0) txt.push_back(8'(CH_ZERO + empties));
      if (rk < 7) txt.push_back(CH_SLASH);
    end
    add_blanks(txt);
    txt.push_back($urandom_range(0, 1) ? CH_LO_B : CH_LO_W);
    // The side letter may run straight into the castling field.
    if ($urandom_range(0, 99) >= 15) add_blanks(txt);
    if ($urandom_range(0, 99) < 30) begin
      txt.push_back(CH_DASH);
    end else begin
      n = 0;
      for (fl = 0; fl < 4; fl++) begin
        if ($urandom_range(0, 1)) begin
          txt.push_back(rights[fl]);
          n++;
        end
      end
      if (n == 0) txt.push_back(CH_DASH);
    end
    add_blanks(txt);
    if ($urandom_range(0, 1)) begin
      txt.push_back(CH_DASH);
    end else begin
      txt.push_back(8'(CH_LO_A + $urandom_range(0, 7)));
      txt.push_back(8'(CH_ONE + $urandom_range(0, 7)));
    end
    add_blanks(txt);
    append_counter(txt, 1'b0);
    add_blanks(txt);
    append_counter(txt, 1'b1);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      add_blanks(txt);
      repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(33, 126)));
    end else if (pick < 20) begin
      add_blanks(txt);
    end
    // Corruptions.
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 18) begin
      n = $urandom_range(1, txt.size());
      while (txt.size() > n) void'(txt.pop_back());
    end else if (pick < 24) begin
      txt.insert($urandom_range(0, txt.size() - 1), 8'($urandom_range(0, 255)));
    end else if (pick < 29) begin
      n = $urandom_range(0, txt.size() - 1);
      txt[n] = txt[n] ^ (8'd1 << $urandom_range(0, 7));
    end else if (pick < 34) begin
      txt = {};
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // ------------------------------------------------------------------
  // Receiver: ready with random stalls, and long stretches without any.
  // ------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    int stall;
    repeat (4) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = idle_length();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------------
  // Main sequence.
  // ------------------------------------------------------------------
  initial begin : text_source
    text_q_t txt;
    int      ci;
    int      i;
    int      sent_bytes;
    clear_parser();
    sent_bytes = 0;

    // Directed strings: legal positions, field extremes and every kind of error.
    add_case("rnbqkbnr/pppppppp/8/8/4P3/8/PPPP1PPP/RNBQKBNR b KQkq e3 0 1",
             1'b1, 1'b1, SIDE_BLACK, CASTLE_WK | CASTLE_WQ | CASTLE_BK | CASTLE_BQ,
             7'd20, 30'd0, 30'd1);
    add_case("8/8/8/8/8/8/8/Kk6 w - - 0 1",
             1'b1, 1'b1, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd1);
    add_case("4k3/8/8/8/8/8/8/4K3 bKq h8 999999999 1000000000",
             1'b1, 1'b1, SIDE_BLACK, CASTLE_WK | CASTLE_BQ, 7'd63, 30'd999999999,
             30'd1000000000);
    add_case("4k3/8/8/8/8/8/8/4K3\011w\012-\015a1\0130\0147",
             1'b0, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w - - 0 0",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w - - 0 1000000001",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w - a 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w - a9 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w -K - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 x - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/08/4K3 w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K2 w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3/8 w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4kk2/8/8/8/8/8/8/4K3 w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w - -",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w k - 3 5 extra tokens 9",
             1'b0, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    // A piece letter on the final byte gives only the verdict.
    add_case("4k3/8/8/8/8/8/8/4K2Q",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3R w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K2X w - - 0 1",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("\377",
             1'b1, 1'b0, SIDE_WHITE, 4'd0, EP_NONE, 30'd0, 30'd0);
    add_case("4k3/8/8/8/8/8/8/4K3 w Qk - 1000000000 4 ",
             1'b1, 1'b1, SIDE_WHITE, CASTLE_WQ | CASTLE_BK, EP_NONE, 30'd1000000000,
             30'd4);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (ci = 0; ci < fen_cases.size(); ci++) begin
      txt = {};
      for (i = 0; i < fen_cases[ci].txt.len(); i++) txt.push_back(fen_cases[ci].txt[i]);
      verdict_typed <= fen_cases[ci].typed;
      verdict_table <= fen_cases[ci].verdict;
      send_text(txt);
      sent_bytes += txt.size();
    end

    // Random positions until the planned number of bytes has been sent.
    verdict_typed <= 1'b0;
    while (sent_bytes < BYTE_GOAL) begin
      build_position(txt);
      send_text(txt);
      sent_bytes += txt.size();
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard limit on the run length.
  initial begin : watchdog
    #4_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
